@@ sv/lpht_pkg.sv @@
// ----------------------------------------------------------------------------
// lpht_pkg
// Shared types and constants of the linear probing hash table unit.
// ----------------------------------------------------------------------------
package lpht_pkg;

  // table geometry; the slot count is a power of two so the home slot is
  // the low bits of the hash and the probe address wraps naturally
  localparam int unsigned SLOT_COUNT  = 1024;
  localparam int unsigned IDX_W       = $clog2(SLOT_COUNT);
  localparam int unsigned KEY_BITS    = 64;
  localparam int unsigned VALUE_BITS  = 64;
  localparam int unsigned KV_W        = KEY_BITS + VALUE_BITS;

  // port widths
  localparam int unsigned KIND_W      = 2;
  localparam int unsigned HASH_W      = 64;
  localparam int unsigned KEY_W       = 64;
  localparam int unsigned VAL_W       = 64;
  localparam int unsigned SLOT_IDX_W  = 10;
  localparam int unsigned PROBE_W     = 11;

  localparam logic [PROBE_W-1:0] MAX_PROBES_RST = PROBE_W'(64);

  typedef enum logic [KIND_W-1:0] {
    KIND_GET    = 2'd0,
    KIND_PUT    = 2'd1,
    KIND_REMOVE = 2'd2
  } kind_e;

  typedef enum logic [1:0] {
    SLOT_EMPTY   = 2'd0,
    SLOT_USED    = 2'd1,
    SLOT_DELETED = 2'd2
  } slot_e;

  typedef enum logic [1:0] {
    FSM_CLEAR,
    FSM_IDLE,
    FSM_READ,
    FSM_EVAL
  } fsm_e;

  // requests from the sequencer to the slot memories
  typedef struct packed {
    logic             st_we;
    logic             kv_we;
    logic [IDX_W-1:0] waddr;
    logic [IDX_W-1:0] raddr;
    logic [1:0]       st_wdata;
    logic [KV_W-1:0]  kv_wdata;
  } mem_req_t;

endpackage

@@ sv/lpht_ram.sv @@
// ----------------------------------------------------------------------------
// lpht_ram
// Generic single write port, single read port RAM with registered read.
// ----------------------------------------------------------------------------
module lpht_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

@@ sv/lpht_ctrl.sv @@
// ----------------------------------------------------------------------------
// lpht_ctrl
// Probe sequencer: clears the slot states, walks the probe window one slot
// at a time through the shared key compare, and registers the result word.
// ----------------------------------------------------------------------------
module lpht_ctrl (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [lpht_pkg::PROBE_W-1:0]        max_probes_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic [lpht_pkg::KIND_W-1:0]         kind_i,
  input  logic [lpht_pkg::HASH_W-1:0]         key_hash_i,
  input  logic [lpht_pkg::KEY_W-1:0]          key_i,
  input  logic [lpht_pkg::VAL_W-1:0]          value_in_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                status_o,
  output logic [lpht_pkg::VAL_W-1:0]          value_out_o,
  output logic [lpht_pkg::SLOT_IDX_W-1:0]     slot_index_o,
  output lpht_pkg::mem_req_t                  mem_req_o,
  input  logic [1:0]                          st_rdata_i,
  input  logic [lpht_pkg::KV_W-1:0]           kv_rdata_i
);

  lpht_pkg::fsm_e                       state_q, state_d;
  logic [lpht_pkg::IDX_W-1:0]           addr_q, addr_d;
  logic [lpht_pkg::PROBE_W-1:0]         cnt_q, cnt_d;
  logic [lpht_pkg::PROBE_W-1:0]         max_probes_q, max_probes_d;
  logic [lpht_pkg::KIND_W-1:0]          kind_q, kind_d;
  logic [lpht_pkg::KEY_BITS-1:0]        key_q, key_d;
  logic [lpht_pkg::VALUE_BITS-1:0]      val_q, val_d;
  logic                                 out_valid_q, out_valid_d;
  logic                                 status_q, status_d;
  logic [lpht_pkg::VAL_W-1:0]           value_out_q, value_out_d;
  logic [lpht_pkg::SLOT_IDX_W-1:0]      slot_index_q, slot_index_d;

  logic key_eq;
  logic last_probe;
  logic out_free;
  logic resolved;
  logic hit;

  assign key_eq     = kv_rdata_i[lpht_pkg::KV_W-1:lpht_pkg::VALUE_BITS] == key_q;
  assign last_probe = (cnt_q + lpht_pkg::PROBE_W'(1)) == max_probes_q;
  assign out_free   = !out_valid_q || out_ready_i;

  // examine the slot just read
  always_comb begin
    resolved = 1'b0;
    hit      = 1'b0;
    if (max_probes_q == '0) begin
      resolved = 1'b1;
    end else begin
      unique case (kind_q)
        lpht_pkg::KIND_GET, lpht_pkg::KIND_REMOVE: begin
          if (st_rdata_i == lpht_pkg::SLOT_EMPTY) begin
            resolved = 1'b1;
          end else if (st_rdata_i == lpht_pkg::SLOT_USED && key_eq) begin
            resolved = 1'b1;
            hit      = 1'b1;
          end
        end
        lpht_pkg::KIND_PUT: begin
          if (st_rdata_i == lpht_pkg::SLOT_EMPTY || st_rdata_i == lpht_pkg::SLOT_DELETED) begin
            resolved = 1'b1;
            hit      = 1'b1;
          end
        end
        default: resolved = 1'b1;
      endcase
      if (!resolved && last_probe) begin
        resolved = 1'b1;
      end
    end
  end

  always_comb begin
    state_d      = state_q;
    addr_d       = addr_q;
    cnt_d        = cnt_q;
    max_probes_d = max_probes_q;
    kind_d       = kind_q;
    key_d        = key_q;
    val_d        = val_q;
    out_valid_d  = out_valid_q && !out_ready_i;
    status_d     = status_q;
    value_out_d  = value_out_q;
    slot_index_d = slot_index_q;
    in_ready_o   = 1'b0;

    mem_req_o          = '0;
    mem_req_o.raddr    = addr_q;
    mem_req_o.waddr    = addr_q;
    mem_req_o.kv_wdata = {key_q, val_q};

    if (cfg_valid_i) begin
      max_probes_d = max_probes_i;
    end

    unique case (state_q)
      lpht_pkg::FSM_CLEAR: begin
        mem_req_o.st_we    = 1'b1;
        mem_req_o.st_wdata = lpht_pkg::SLOT_EMPTY;
        addr_d             = addr_q + lpht_pkg::IDX_W'(1);
        if (addr_q == lpht_pkg::IDX_W'(lpht_pkg::SLOT_COUNT - 1)) begin
          state_d = lpht_pkg::FSM_IDLE;
        end
      end
      lpht_pkg::FSM_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          addr_d  = key_hash_i[lpht_pkg::IDX_W-1:0];
          cnt_d   = '0;
          kind_d  = kind_i;
          key_d   = key_i[lpht_pkg::KEY_BITS-1:0];
          val_d   = value_in_i[lpht_pkg::VALUE_BITS-1:0];
          state_d = lpht_pkg::FSM_READ;
        end
      end
      lpht_pkg::FSM_READ: begin
        state_d = lpht_pkg::FSM_EVAL;
      end
      lpht_pkg::FSM_EVAL: begin
        if (!resolved) begin
          addr_d  = addr_q + lpht_pkg::IDX_W'(1);
          cnt_d   = cnt_q + lpht_pkg::PROBE_W'(1);
          state_d = lpht_pkg::FSM_READ;
        end else if (out_free) begin
          // finish: commit the slot update together with the result word
          out_valid_d  = 1'b1;
          status_d     = !hit;
          value_out_d  = '0;
          slot_index_d = '0;
          if (hit) begin
            slot_index_d = lpht_pkg::SLOT_IDX_W'(addr_q);
            unique case (kind_q)
              lpht_pkg::KIND_GET: begin
                value_out_d = lpht_pkg::VAL_W'(kv_rdata_i[lpht_pkg::VALUE_BITS-1:0]);
              end
              lpht_pkg::KIND_PUT: begin
                mem_req_o.st_we    = 1'b1;
                mem_req_o.kv_we    = 1'b1;
                mem_req_o.st_wdata = lpht_pkg::SLOT_USED;
              end
              lpht_pkg::KIND_REMOVE: begin
                mem_req_o.st_we    = 1'b1;
                mem_req_o.st_wdata = lpht_pkg::SLOT_DELETED;
              end
              default: ;
            endcase
          end
          state_d = lpht_pkg::FSM_IDLE;
        end
        // result register still full: hold here, same slot is reread
      end
      default: state_d = lpht_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= lpht_pkg::FSM_CLEAR;
      addr_q       <= '0;
      cnt_q        <= '0;
      max_probes_q <= lpht_pkg::MAX_PROBES_RST;
      kind_q       <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      addr_q       <= addr_d;
      cnt_q        <= cnt_d;
      max_probes_q <= max_probes_d;
      kind_q       <= kind_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    key_q        <= key_d;
    val_q        <= val_d;
    status_q     <= status_d;
    value_out_q  <= value_out_d;
    slot_index_q <= slot_index_d;
  end

  assign cfg_ready_o  = 1'b1;
  assign out_valid_o  = out_valid_q;
  assign status_o     = status_q;
  assign value_out_o  = value_out_q;
  assign slot_index_o = slot_index_q;

endmodule

@@ sv/linear_probe_hash_table_unit.sv @@
// ----------------------------------------------------------------------------
// linear_probe_hash_table_unit
// Open addressing hash table with linear probing, tombstones and a
// configurable probe limit; get, put and remove one word at a time.
// ----------------------------------------------------------------------------
//
//  channel  direction  handshake                signals
//  -------  ---------  -----------------------  -------------------------------
//  cfg      in         cfg_valid_i/cfg_ready_o  max_probes_i
//  in       in         in_valid_i/in_ready_o    kind_i key_hash_i key_i value_in_i
//  out      out        out_valid_o/out_ready_i  status_o value_out_o slot_index_o
//
//  an operation examines one or more slots; each probe is a slot memory
//  read followed, for get and remove, by one key compare
//  after reset a clearing pass marks all 1024 slots empty with in_ready_o
//  low; cfg writes are taken at any time
//  the result word sits in an output register, so the next word is accepted
//  while it waits; a probe that resolves while that register is full holds
//  until out_ready_i frees it
// ----------------------------------------------------------------------------
module linear_probe_hash_table_unit (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  // probe limit register
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [lpht_pkg::PROBE_W-1:0]    max_probes_i,
  // operation words
  input  logic                            in_valid_i,
  output logic                            in_ready_o,
  input  logic [lpht_pkg::KIND_W-1:0]     kind_i,
  input  logic [lpht_pkg::HASH_W-1:0]     key_hash_i,
  input  logic [lpht_pkg::KEY_W-1:0]      key_i,
  input  logic [lpht_pkg::VAL_W-1:0]      value_in_i,
  // result words
  output logic                            out_valid_o,
  input  logic                            out_ready_i,
  output logic                            status_o,
  output logic [lpht_pkg::VAL_W-1:0]      value_out_o,
  output logic [lpht_pkg::SLOT_IDX_W-1:0] slot_index_o
);

  lpht_pkg::mem_req_t          mem_req;
  logic [1:0]                  st_rdata;
  logic [lpht_pkg::KV_W-1:0]   kv_rdata;

  // sequencer: owns the probe address, probe count and result register
  lpht_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .max_probes_i (max_probes_i),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .key_hash_i   (key_hash_i),
    .key_i        (key_i),
    .value_in_i   (value_in_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .status_o     (status_o),
    .value_out_o  (value_out_o),
    .slot_index_o (slot_index_o),
    .mem_req_o    (mem_req),
    .st_rdata_i   (st_rdata),
    .kv_rdata_i   (kv_rdata)
  );

  // slot state: empty, used or deleted; cleared by the pass after reset
  lpht_ram #(
    .WIDTH (2),
    .DEPTH (lpht_pkg::SLOT_COUNT)
  ) u_state_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.st_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.st_wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (st_rdata)
  );

  // stored key and value, read with every slot state but only used behind a used one
  lpht_ram #(
    .WIDTH (lpht_pkg::KV_W),
    .DEPTH (lpht_pkg::SLOT_COUNT)
  ) u_kv_ram (
    .clk_i   (clk_i),
    .we_i    (mem_req.kv_we),
    .waddr_i (mem_req.waddr),
    .wdata_i (mem_req.kv_wdata),
    .raddr_i (mem_req.raddr),
    .rdata_o (kv_rdata)
  );

endmodule
